### hw/rtl/psfd_pkg.sv
`timescale 1ns / 1ps

package psfd_pkg;

   // Default coordinate width and the fixed width of the distance word.
   localparam int COORD_WIDTH_DEFAULT = 31;
   localparam int DIST_WIDTH          = 32;

   // An upper bound on any distance that a legal input can produce.
   localparam logic [DIST_WIDTH-1:0] DIST_LIMIT = 32'd3037000499;

   // Which part of the segment is nearest to the point.
   typedef enum logic [1:0] {
      CASE_DEGENERATE = 2'd0,
      CASE_START      = 2'd1,
      CASE_END        = 2'd2,
      CASE_INTERIOR   = 2'd3
   } case_type;

   localparam int CASE_WIDTH = 2;

endpackage

### hw/rtl/point_segment_floor_distance_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports
// request   in         req_valid, req_ready, req_point_x/y, req_start_x/y, req_end_x/y
// response  out        rsp_valid, rsp_ready, rsp_distance, rsp_nearest_case
//
// One word enters per cycle while req_ready is high; the depth is set by the front stages,
// the 2*COORD_WIDTH+1 divider stages, the COORD_WIDTH+1 root stages and the output register.
// Reset clears every valid bit of the pipeline and the valid bit of the output register.
// When a response word is held by rsp_ready low, the whole pipeline holds;
// req_ready is low only in that case, and no word is lost or repeated.
module point_segment_floor_distance_unit #(
   parameter int COORD_WIDTH = psfd_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [COORD_WIDTH-1:0]            req_point_x,
   input  logic [COORD_WIDTH-1:0]            req_point_y,
   input  logic [COORD_WIDTH-1:0]            req_start_x,
   input  logic [COORD_WIDTH-1:0]            req_start_y,
   input  logic [COORD_WIDTH-1:0]            req_end_x,
   input  logic [COORD_WIDTH-1:0]            req_end_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [psfd_pkg::DIST_WIDTH-1:0]   rsp_distance,
   output logic [psfd_pkg::CASE_WIDTH-1:0]   rsp_nearest_case
);

   localparam int DW  = COORD_WIDTH + 1;      // coordinate difference
   localparam int PW  = 2 * DW;               // product and sum of products
   localparam int MW  = PW;                   // magnitude of cross, squared length
   localparam int HW  = MW / 2;               // half of a magnitude
   localparam int SW  = 2 * COORD_WIDTH + 1;  // squared distance
   localparam int RW  = COORD_WIDTH + 1;      // distance
   localparam int CW  = psfd_pkg::CASE_WIDTH;
   localparam int SDW = CW + SW;

   logic en;

   // Stage 1: sign-extended coordinates.
   logic signed [DW-1:0] s1_px_ff, s1_py_ff, s1_ux_ff, s1_uy_ff, s1_vx_ff, s1_vy_ff;
   logic                 s1_vld_ff;
   // Stage 2: differences.
   logic signed [DW-1:0] s2_ex_ff, s2_ey_ff, s2_dx_ff, s2_dy_ff, s2_fx_ff, s2_fy_ff;
   logic                 s2_vld_ff;
   // Stage 3: products.
   logic signed [PW-1:0] s3_exex_ff, s3_eyey_ff, s3_fxfx_ff, s3_fyfy_ff;
   logic signed [PW-1:0] s3_exdx_ff, s3_eydy_ff, s3_dxdx_ff, s3_dydy_ff;
   logic signed [PW-1:0] s3_dxey_ff, s3_dyex_ff;
   logic                 s3_vld_ff;
   // Stage 4: dot product, squared length, cross product, squared endpoint distances.
   logic signed [PW-1:0] s4_t_ff, s4_den_ff, s4_cross_ff, s4_du_ff, s4_dv_ff;
   logic                 s4_vld_ff;
   // Stage 5: case decision.
   psfd_pkg::case_type   s5_case_ff, s5_case_in;
   logic [MW-1:0]        s5_mag_ff, s5_den_ff;
   logic [SW-1:0]        s5_plain_ff, s5_plain_in;
   logic                 s5_vld_ff;
   // Stage 6: partial products of the cross magnitude squared.
   logic [2*HW-1:0]      s6_hh_ff, s6_hl_ff, s6_ll_ff;
   logic [MW-1:0]        s6_den_ff;
   logic [SDW-1:0]       s6_side_ff;
   logic                 s6_vld_ff;
   // Stage 7: full cross magnitude squared.
   logic [2*MW-1:0]      s7_num_ff;
   logic [MW-1:0]        s7_den_ff;
   logic [SDW-1:0]       s7_side_ff;
   logic                 s7_vld_ff;

   logic                 div_vld;
   logic [SW-1:0]        div_quo;
   logic [SDW-1:0]       div_side;
   psfd_pkg::case_type   div_case;
   logic [SW-1:0]        sq_value;

   logic                 sq_vld;
   logic [RW-1:0]        sq_root;
   logic [CW-1:0]        sq_case;

   logic                                rsp_valid_ff;
   logic [psfd_pkg::DIST_WIDTH-1:0]     rsp_distance_ff;
   logic [CW-1:0]                       rsp_nearest_case_ff;

   // The pipeline moves whenever the output register is free or being drained.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   // Case selection and the squared endpoint distance that goes with it.
   always_comb begin
      if (s4_den_ff == '0) begin
         s5_case_in  = psfd_pkg::CASE_DEGENERATE;
         s5_plain_in = s4_du_ff[SW-1:0];
      end else if (s4_t_ff[PW-1] || (s4_t_ff == '0)) begin
         s5_case_in  = psfd_pkg::CASE_START;
         s5_plain_in = s4_du_ff[SW-1:0];
      end else if (s4_t_ff >= s4_den_ff) begin
         s5_case_in  = psfd_pkg::CASE_END;
         s5_plain_in = s4_dv_ff[SW-1:0];
      end else begin
         s5_case_in  = psfd_pkg::CASE_INTERIOR;
         s5_plain_in = '0;
      end
   end

   // Front pipeline payload.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_px_ff <= $signed({req_point_x[COORD_WIDTH-1], req_point_x});
         s1_py_ff <= $signed({req_point_y[COORD_WIDTH-1], req_point_y});
         s1_ux_ff <= $signed({req_start_x[COORD_WIDTH-1], req_start_x});
         s1_uy_ff <= $signed({req_start_y[COORD_WIDTH-1], req_start_y});
         s1_vx_ff <= $signed({req_end_x[COORD_WIDTH-1], req_end_x});
         s1_vy_ff <= $signed({req_end_y[COORD_WIDTH-1], req_end_y});

         s2_ex_ff <= s1_px_ff - s1_ux_ff;
         s2_ey_ff <= s1_py_ff - s1_uy_ff;
         s2_dx_ff <= s1_vx_ff - s1_ux_ff;
         s2_dy_ff <= s1_vy_ff - s1_uy_ff;
         s2_fx_ff <= s1_px_ff - s1_vx_ff;
         s2_fy_ff <= s1_py_ff - s1_vy_ff;

         s3_exex_ff <= s2_ex_ff * s2_ex_ff;
         s3_eyey_ff <= s2_ey_ff * s2_ey_ff;
         s3_fxfx_ff <= s2_fx_ff * s2_fx_ff;
         s3_fyfy_ff <= s2_fy_ff * s2_fy_ff;
         s3_exdx_ff <= s2_ex_ff * s2_dx_ff;
         s3_eydy_ff <= s2_ey_ff * s2_dy_ff;
         s3_dxdx_ff <= s2_dx_ff * s2_dx_ff;
         s3_dydy_ff <= s2_dy_ff * s2_dy_ff;
         s3_dxey_ff <= s2_dx_ff * s2_ey_ff;
         s3_dyex_ff <= s2_dy_ff * s2_ex_ff;

         s4_t_ff     <= s3_exdx_ff + s3_eydy_ff;
         s4_den_ff   <= s3_dxdx_ff + s3_dydy_ff;
         s4_cross_ff <= s3_dxey_ff - s3_dyex_ff;
         s4_du_ff    <= s3_exex_ff + s3_eyey_ff;
         s4_dv_ff    <= s3_fxfx_ff + s3_fyfy_ff;

         s5_case_ff  <= s5_case_in;
         s5_plain_ff <= s5_plain_in;
         s5_den_ff   <= $unsigned(s4_den_ff);
         s5_mag_ff   <= s4_cross_ff[PW-1] ? $unsigned(-s4_cross_ff) : $unsigned(s4_cross_ff);

         s6_hh_ff   <= s5_mag_ff[MW-1:HW] * s5_mag_ff[MW-1:HW];
         s6_hl_ff   <= s5_mag_ff[MW-1:HW] * s5_mag_ff[HW-1:0];
         s6_ll_ff   <= s5_mag_ff[HW-1:0] * s5_mag_ff[HW-1:0];
         s6_den_ff  <= s5_den_ff;
         s6_side_ff <= {s5_case_ff, s5_plain_ff};

         s7_num_ff  <= ((2*MW)'(s6_hh_ff) << MW) + ((2*MW)'(s6_hl_ff) << (HW + 1))
                       + (2*MW)'(s6_ll_ff);
         s7_den_ff  <= s6_den_ff;
         s7_side_ff <= s6_side_ff;
      end
   end

   // Cross magnitude squared over squared length, floored.
   psfd_div #(
      .NUM_W  (2 * MW),
      .DEN_W  (MW),
      .QUO_W  (SW),
      .SIDE_W (SDW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s7_vld_ff),
      .in_num    (s7_num_ff),
      .in_den    (s7_den_ff),
      .in_side   (s7_side_ff),
      .out_valid (div_vld),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // The interior case takes the quotient, the others their endpoint distance.
   assign div_case = psfd_pkg::case_type'(div_side[SDW-1:SW]);
   assign sq_value = (div_case == psfd_pkg::CASE_INTERIOR) ? div_quo : div_side[SW-1:0];

   psfd_sqrt #(
      .IN_W   (SW),
      .ROOT_W (RW),
      .SIDE_W (CW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_vld),
      .in_value  (sq_value),
      .in_side   (div_side[SDW-1:SW]),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_case)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sq_vld;
      end
      if (en) begin
         rsp_distance_ff     <= psfd_pkg::DIST_WIDTH'(sq_root);
         rsp_nearest_case_ff <= sq_case;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance     = rsp_distance_ff;
   assign rsp_nearest_case = rsp_nearest_case_ff;

   // A degenerate decision only ever comes from a zero squared length.
   a_degenerate_den : assert property (@(posedge clock) disable iff (reset)
      (s5_vld_ff && (s5_case_ff == psfd_pkg::CASE_DEGENERATE)) |-> (s5_den_ff == '0))
      else $error("degenerate case with nonzero squared length");

   // No distance can exceed DIST_LIMIT.
   a_dist_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance <= psfd_pkg::DIST_LIMIT))
      else $error("distance out of range");

   // While the output is held, the front of the pipeline holds as well.
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(s1_vld_ff) && $stable(s7_vld_ff)))
      else $error("pipeline moved during a stall");

endmodule

### hw/rtl/psfd_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage.
// The quotient must fit in QUO_W bits, which means num >> QUO_W < den.
module psfd_div #(
   parameter int NUM_W  = 128,
   parameter int DEN_W  = 64,
   parameter int QUO_W  = 63,
   parameter int SIDE_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic [DEN_W:0]    rem_ff  [1:QUO_W];
   logic [QUO_W-1:0]  low_ff  [1:QUO_W];
   logic [QUO_W-1:0]  quo_ff  [1:QUO_W];
   logic [DEN_W-1:0]  den_ff  [1:QUO_W];
   logic [SIDE_W-1:0] side_ff [1:QUO_W];
   logic              vld_ff  [1:QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [DEN_W:0]    cur_rem;
      logic [QUO_W-1:0]  cur_low;
      logic [QUO_W-1:0]  cur_quo;
      logic [DEN_W-1:0]  cur_den;
      logic [SIDE_W-1:0] cur_side;
      logic              cur_vld;
      logic [DEN_W:0]    shifted;
      logic              ge;

      // The first stage takes the top of the dividend straight from the inputs.
      if (i == 0) begin : g_first
         assign cur_rem  = in_num[NUM_W-1:QUO_W];
         assign cur_low  = in_num[QUO_W-1:0];
         assign cur_quo  = '0;
         assign cur_den  = in_den;
         assign cur_side = in_side;
         assign cur_vld  = in_valid;
      end else begin : g_next
         assign cur_rem  = rem_ff[i];
         assign cur_low  = low_ff[i];
         assign cur_quo  = quo_ff[i];
         assign cur_den  = den_ff[i];
         assign cur_side = side_ff[i];
         assign cur_vld  = vld_ff[i];
      end

      // Bring down the next dividend bit and try one subtraction.
      assign shifted = {cur_rem[DEN_W-1:0], cur_low[QUO_W-1]};
      assign ge      = (shifted >= {1'b0, cur_den});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= cur_vld;
         end
         if (en) begin
            rem_ff[i+1]  <= ge ? (shifted - {1'b0, cur_den}) : shifted;
            low_ff[i+1]  <= cur_low << 1;
            quo_ff[i+1]  <= {cur_quo[QUO_W-2:0], ge};
            den_ff[i+1]  <= cur_den;
            side_ff[i+1] <= cur_side;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

### hw/rtl/psfd_sqrt.sv
`timescale 1ns / 1ps

// Pipelined digit-by-digit integer square root: one root bit per stage.
module psfd_sqrt #(
   parameter int IN_W   = 63,
   parameter int ROOT_W = 32,
   parameter int SIDE_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   in_value,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int TW = 2 * ROOT_W + 1;

   logic [TW-1:0]     rem_ff  [1:ROOT_W];
   logic [ROOT_W-1:0] root_ff [1:ROOT_W];
   logic [SIDE_W-1:0] side_ff [1:ROOT_W];
   logic              vld_ff  [1:ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int B = ROOT_W - 1 - i;
      logic [TW-1:0]     cur_rem;
      logic [ROOT_W-1:0] cur_root;
      logic [SIDE_W-1:0] cur_side;
      logic              cur_vld;
      logic [TW-1:0]     trial;
      logic              ge;

      if (i == 0) begin : g_first
         assign cur_rem  = TW'(in_value);
         assign cur_root = '0;
         assign cur_side = in_side;
         assign cur_vld  = in_valid;
      end else begin : g_next
         assign cur_rem  = rem_ff[i];
         assign cur_root = root_ff[i];
         assign cur_side = side_ff[i];
         assign cur_vld  = vld_ff[i];
      end

      // Setting bit B adds 2*root*2^B + 2^(2B) to the square.
      assign trial = (TW'(cur_root) << (B + 1)) | (TW'(1) << (2 * B));
      assign ge    = (cur_rem >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= cur_vld;
         end
         if (en) begin
            rem_ff[i+1]  <= ge ? (cur_rem - trial) : cur_rem;
            root_ff[i+1] <= ge ? (cur_root | (ROOT_W'(1) << B)) : cur_root;
            side_ff[i+1] <= cur_side;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

### tb/sv/tb_point_segment_floor_distance_unit.sv
`timescale 1ns / 1ps

module tb_point_segment_floor_distance_unit;

   localparam int CW      = psfd_pkg::COORD_WIDTH_DEFAULT;
   localparam int LATENCY = 3 * CW + 10;

   typedef logic [CW-1:0] coord_type;

   typedef struct {
      logic [psfd_pkg::DIST_WIDTH-1:0] distance;
      psfd_pkg::case_type              nearest;
   } floor_distance_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_point_x = '0, req_point_y = '0;
   coord_type req_start_x = '0, req_start_y = '0;
   coord_type req_end_x = '0, req_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [psfd_pkg::DIST_WIDTH-1:0] rsp_distance;
   logic [psfd_pkg::CASE_WIDTH-1:0] rsp_nearest_case;

   floor_distance_type pending_distances[$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   point_segment_floor_distance_unit #(.COORD_WIDTH(CW)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance), .rsp_nearest_case(rsp_nearest_case)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Narrow a small integer to one coordinate.
   function automatic coord_type crd(int value);
      return coord_type'(value);
   endfunction

   // Largest k up to the limit with k*k*den <= num_sq; den of one gives a plain root.
   function automatic logic [psfd_pkg::DIST_WIDTH-1:0] floor_root(logic [127:0] num_sq,
                                                                  logic [127:0] den);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = psfd_pkg::DIST_WIDTH - 1; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand <= 64'(psfd_pkg::DIST_LIMIT) && (128'(cand) * 128'(cand) * den) <= num_sq)
            root = cand;
      end
      return root[psfd_pkg::DIST_WIDTH-1:0];
   endfunction

   // Expected distance and nearest part of the segment for one query.
   function automatic floor_distance_type predict_distance(coord_type px, coord_type py,
         coord_type sx, coord_type sy, coord_type ex_, coord_type ey_);
      logic signed [127:0] cx, cy, ux, uy, vx, vy, dx, dy, ox, oy, fx, fy;
      logic signed [127:0] dot, den, cross_prod;
      floor_distance_type res;
      cx = 128'(signed'(px));  cy = 128'(signed'(py));
      ux = 128'(signed'(sx));  uy = 128'(signed'(sy));
      vx = 128'(signed'(ex_)); vy = 128'(signed'(ey_));
      dx = vx - ux; dy = vy - uy;
      ox = cx - ux; oy = cy - uy;
      fx = cx - vx; fy = cy - vy;
      dot = ox * dx + oy * dy;
      den = dx * dx + dy * dy;
      cross_prod = dx * oy - dy * ox;
      if (dx == 0 && dy == 0) begin
         res.distance = floor_root(ox * ox + oy * oy, 128'd1);
         res.nearest  = psfd_pkg::CASE_DEGENERATE;
      end else if (dot <= 0) begin
         res.distance = floor_root(ox * ox + oy * oy, 128'd1);
         res.nearest  = psfd_pkg::CASE_START;
      end else if (dot >= den) begin
         res.distance = floor_root(fx * fx + fy * fy, 128'd1);
         res.nearest  = psfd_pkg::CASE_END;
      end else begin
         res.distance = floor_root(cross_prod * cross_prod, den);
         res.nearest  = psfd_pkg::CASE_INTERIOR;
      end
      return res;
   endfunction

   // Send one query word and record its expected result on acceptance.
   task automatic send_query(coord_type px, coord_type py, coord_type sx, coord_type sy,
                             coord_type ex_, coord_type ey_);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= px;  req_point_y <= py;
      req_start_x <= sx;  req_start_y <= sy;
      req_end_x   <= ex_; req_end_y   <= ey_;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_distances = {pending_distances, predict_distance(px, py, sx, sy, ex_, ey_)};
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Receiver stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      floor_distance_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_distances.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result word: distance %0d case %0d",
                        rsp_distance, rsp_nearest_case);
         end else begin
            want = pending_distances.pop_front();
            if (rsp_distance !== want.distance || rsp_nearest_case !== want.nearest) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected distance %0d case %0d, got %0d case %0d",
                           want.distance, want.nearest, rsp_distance, rsp_nearest_case);
            end
         end
      end
   end

   function automatic coord_type random_coord(int spread);
      case (spread)
         0: return coord_type'($urandom_range(200) - 100);
         1: return coord_type'($urandom_range(2000000) - 1000000);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Extreme coordinates, endpoints, degenerate segments, feet on endpoints, interior feet and points on the line.
   task automatic test_directed();
      coord_type mn, mx;
      mn = {1'b1, {(CW-1){1'b0}}};
      mx = {1'b0, {(CW-1){1'b1}}};
      send_query(mn, mn, mn, mn, mn, mn);
      send_query(mx, mx, mx, mx, mx, mx);
      send_query(mn, mn, mx, mx, mx, mx);
      send_query(mx, mn, mn, mx, mn, mx);
      send_query(mn, mx, mx, mn, mn, mn);
      send_query(mx, mx, mn, mn, mx, mn);
      send_query(mn, mn, mn, mx, mx, mn);
      send_query(mx, mx, mn, mn, mx, mx);
      send_query(mx, crd(0), mn, crd(0), mx, crd(0));
      send_query(crd(0), crd(0), crd(0), crd(0), crd(0), crd(0));
      send_query(crd(3), crd(4), crd(0), crd(0), crd(0), crd(0));
      send_query(crd(0), crd(5), crd(0), crd(0), crd(10), crd(0));
      send_query(crd(10), crd(5), crd(0), crd(0), crd(10), crd(0));
      send_query(crd(-3), crd(4), crd(0), crd(0), crd(10), crd(0));
      send_query(crd(13), crd(-4), crd(0), crd(0), crd(10), crd(0));
      send_query(crd(5), crd(0), crd(0), crd(0), crd(10), crd(0));
      send_query(crd(5), crd(5), crd(0), crd(0), crd(10), crd(10));
      send_query(crd(2), crd(7), crd(0), crd(0), crd(10), crd(0));
      send_query(crd(1), crd(1), crd(0), crd(0), crd(3), crd(1));
      send_query(mx, mn, crd(0), crd(0), crd(1), crd(0));
      send_query(crd(-1), crd(-1), crd(0), crd(0), crd(-1), crd(-1));
      send_query(crd(0), mx, mn, crd(0), mx, crd(0));
      wait_drain();
   endtask

   // Random queries at one spread mix, with mostly bounded coordinates.
   task automatic test_random(int count);
      coord_type px, py, sx, sy;
      int sp;
      for (int i = 0; i < count; i++) begin
         sp = $urandom_range(4) == 0 ? 2 : $urandom_range(1);
         px = random_coord(sp); py = random_coord(sp);
         sx = random_coord(sp); sy = random_coord(sp);
         if ($urandom_range(9) == 0)
            send_query(px, py, sx, sy, sx, sy);
         else
            send_query(px, py, sx, sy, random_coord(sp), random_coord(sp));
      end
      wait_drain();
   endtask

   task automatic test_no_idle();
      send_idle_pct = 0;  recv_stall_pct = 0;
      test_random(350);
   endtask

   task automatic test_sender_idle();
      send_idle_pct = 86; recv_stall_pct = 0;
      test_random(350);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;  recv_stall_pct = 86;
      test_random(350);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 21; recv_stall_pct = 21;
      test_random(350);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      if (mismatch_count == 0 && pending_distances.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Run limit well above the slowest correct run.
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/psfd_pkg.sv
hw/rtl/psfd_div.sv
hw/rtl/psfd_sqrt.sv
hw/rtl/point_segment_floor_distance_unit.sv
tb/sv/tb_point_segment_floor_distance_unit.sv
